// ===== sv/sws_pkg.sv =====
// ---------------------------------------------------------------------------
// sws_pkg
// Shared types and constants for the sliding window statistics unit.
// ---------------------------------------------------------------------------
package sws_pkg;

   localparam int SampleW = 32;
   localparam int TimeW   = 48;
   localparam int HzW     = 20;
   localparam int SpanW   = 9;
   localparam int SumW    = 41;
   localparam int CsrIdxW = 3;

   // Microseconds per second, dividend of the sampling interval
   localparam logic [HzW-1:0] UsPerSecond = 20'd1000000;

   // Configuration register indexes
   localparam logic [CsrIdxW-1:0] CSR_SAMPLING_HZ    = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_TRACKING_SPAN  = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_MODULE_ENABLED = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_PANEL_VISIBLE  = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_BACKGROUND     = 3'd4;

   // Input item function codes
   localparam logic FUNC_PUSH  = 1'b0;
   localparam logic FUNC_CLEAR = 1'b1;

   typedef struct packed {
      logic                      func;
      logic signed [SampleW-1:0] sample_value;
      logic [TimeW-1:0]          time_us;
      logic                      playing;
      logic                      paused;
   } req_type;

   typedef struct packed {
      logic                      accepted;
      logic signed [SampleW-1:0] current_value;
      logic signed [SampleW-1:0] average_value;
      logic signed [SampleW-1:0] minimum_value;
      logic signed [SampleW-1:0] maximum_value;
      logic [SpanW-1:0]          sample_count;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic clear;       // zero statistics
      logic latch;       // capture the request and start the interval division
      logic record;      // write sample, update count, sum and pointer
      logic restart;     // window does not fit the span: zero pointer, count, sum
      logic ext_update;  // fold new sample into extrema
      logic scan_start;  // begin extremum rescan
      logic scan_step;   // read one ring entry
      logic div_start;   // begin average division
      logic div_step;    // one quotient bit
      logic int_step;    // one bit of the interval division
      logic mem_rd_old;  // read entry under write pointer
      logic rsp_load;    // load result register
      logic accept_flag; // the item was recorded
   } sws_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic gate_open;   // every condition to record holds
      logic int_done;
      logic needs_restart;
      logic was_full;
      logic old_is_ext;
      logic first_sample;
      logic scan_done;
      logic div_done;
   } sws_sts_type;

endpackage

// ===== sv/sws_ram.sv =====
// ---------------------------------------------------------------------------
// sws_ram
// Generic single port RAM with registered read.
// ---------------------------------------------------------------------------
module sws_ram #(
   parameter int Width = 32,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end

endmodule

// ===== sv/sws_datapath.sv =====
// ---------------------------------------------------------------------------
// sws_datapath
// Registers, ring memory, gate logic and the shared serial divider.
// ---------------------------------------------------------------------------
module sws_datapath #(
   parameter int MaxSpan = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   input  sws_pkg::req_type             req_data,
   input  logic                         csr_valid,
   input  logic                         csr_ready,
   input  logic [sws_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [31:0]                  csr_wdata,
   input  sws_pkg::sws_cmd_type         cmd,
   output sws_pkg::sws_sts_type         sts,
   output sws_pkg::rsp_type             rsp_data
);
   import sws_pkg::*;

   localparam int PtrW = (MaxSpan > 1) ? $clog2(MaxSpan) : 1;
   localparam int CntW = $clog2(MaxSpan + 1);
   localparam int CmpW = (CntW > SpanW + 1) ? CntW : SpanW + 1;
   localparam logic [CmpW-1:0] MaxSpanC = CmpW'(MaxSpan);

   // Configuration registers
   logic [HzW-1:0]   hz_ff;
   logic [SpanW-1:0] span_ff;
   logic             en_ff, panel_ff, bg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hz_ff    <= HzW'(60);
         span_ff  <= SpanW'(200);
         en_ff    <= 1'b1;
         panel_ff <= 1'b0;
         bg_ff    <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SAMPLING_HZ:    hz_ff    <= csr_wdata[HzW-1:0];
            CSR_TRACKING_SPAN:  span_ff  <= csr_wdata[SpanW-1:0];
            CSR_MODULE_ENABLED: en_ff    <= csr_wdata[0];
            CSR_PANEL_VISIBLE:  panel_ff <= csr_wdata[0];
            CSR_BACKGROUND:     bg_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Effective span, clamped to 1..MaxSpan (compared wide enough for both)
   logic [CmpW-1:0] span_w;
   logic [CntW-1:0] span_eff;
   always_comb begin
      span_w = CmpW'(span_ff);
      if (span_w == '0) span_w = CmpW'(1);
      if (span_w > MaxSpanC) span_w = MaxSpanC;
      span_eff = CntW'(span_w);
   end

   // Statistics state
   req_type                req_ff;
   logic [PtrW-1:0]        wp_ff;
   logic [CntW-1:0]        cnt_ff;
   logic signed [SumW-1:0] sum_ff;
   logic signed [SampleW-1:0] newest_ff, mean_ff, lo_ff, hi_ff, old_ff;
   logic [TimeW-1:0]       last_t_ff;
   logic                   last_ok_ff;
   logic                   full_ff;

   // Shared restoring divider: interval (20b) and average (41b / count)
   logic [SumW-1:0]        dq_ff;   // dividend shifting to quotient
   logic [SumW-1:0]        dr_ff;   // partial remainder
   logic [SumW-1:0]        dd_ff;   // divisor
   logic [6:0]             dn_ff;   // bits left
   logic                   dneg_ff;

   logic [SumW-1:0] dr_shift, dr_sub;
   logic            dr_ge;
   always_comb begin
      dr_shift = {dr_ff[SumW-2:0], dq_ff[SumW-1]};
      dr_ge    = dr_shift >= dd_ff;
      dr_sub   = dr_shift - dd_ff;
   end

   // Rescan index and memory address
   logic [CntW-1:0] scan_ff;
   logic            scan_rd_ff, scan_first_ff;
   logic [PtrW-1:0] mem_addr;
   logic signed [SampleW-1:0] mem_rd;

   always_comb begin
      if (cmd.scan_step) mem_addr = scan_ff[PtrW-1:0];
      else               mem_addr = wp_ff;
   end

   sws_ram #(.Width(SampleW), .Depth(1 << PtrW)) u_ring (
      .clock   (clock),
      .wr_en   (cmd.record),
      .addr    (mem_addr),
      .wr_data (req_ff.sample_value),
      .rd_data (mem_rd)
   );

   // Gate and window checks
   logic [TimeW-1:0] elapsed;
   logic             t_ok;
   always_comb begin
      elapsed = req_ff.time_us - last_t_ff;
      t_ok = (hz_ff == '0) || !last_ok_ff ||
             ((req_ff.time_us >= last_t_ff) &&
              (elapsed >= TimeW'(dq_ff[HzW-1:0])));
      sts.gate_open = en_ff && (panel_ff || bg_ff) && req_ff.playing &&
                      !req_ff.paused && t_ok;
      sts.int_done  = (dn_ff == '0);
      sts.div_done  = (dn_ff == '0);
      sts.needs_restart = (cnt_ff > span_eff) || (CntW'(wp_ff) >= span_eff) ||
                          ((cnt_ff < span_eff) && (CntW'(wp_ff) != cnt_ff));
      sts.was_full  = full_ff;
      sts.old_is_ext = (old_ff == lo_ff) || (old_ff == hi_ff);
      sts.first_sample = (cnt_ff == CntW'(1));
      sts.scan_done = !scan_rd_ff && (scan_ff >= cnt_ff);
   end

   logic [CntW:0] wp_next;
   always_comb wp_next = {1'b0, CntW'(wp_ff)} + 1'b1;

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         wp_ff      <= '0;
         cnt_ff     <= '0;
         sum_ff     <= '0;
         newest_ff  <= '0;
         mean_ff    <= '0;
         lo_ff      <= '0;
         hi_ff      <= '0;
         last_t_ff  <= '0;
         last_ok_ff <= 1'b0;
         full_ff    <= 1'b0;
         dn_ff      <= '0;
         scan_ff    <= '0;
         scan_rd_ff <= 1'b0;
         scan_first_ff <= 1'b0;
         old_ff     <= '0;
      end else begin
         if (cmd.latch) begin
            // Interval = 1e6 / hz, a 20 bit division
            dq_ff <= {UsPerSecond, {(SumW-HzW){1'b0}}};
            dr_ff <= '0;
            dd_ff <= SumW'(hz_ff);
            dn_ff <= (hz_ff == '0) ? 7'd0 : 7'(HzW);
         end
         if (cmd.int_step || cmd.div_step) begin
            dr_ff <= dr_ge ? dr_sub : dr_shift;
            dq_ff <= {dq_ff[SumW-2:0], dr_ge};
            dn_ff <= dn_ff - 1'b1;
         end
         if (cmd.restart) begin
            wp_ff  <= '0;
            cnt_ff <= '0;
            sum_ff <= '0;
         end
         if (cmd.mem_rd_old) begin
            full_ff <= (cnt_ff == span_eff);
         end
         if (cmd.record) begin
            last_t_ff  <= req_ff.time_us;
            last_ok_ff <= 1'b1;
            newest_ff  <= req_ff.sample_value;
            old_ff     <= full_ff ? mem_rd : '0;
            wp_ff      <= (wp_next >= {1'b0, span_eff}) ? '0 : PtrW'(wp_next);
            if (!full_ff) cnt_ff <= cnt_ff + 1'b1;
            sum_ff <= sum_ff + SumW'(req_ff.sample_value) -
                      (full_ff ? SumW'(mem_rd) : SumW'(0));
         end
         if (cmd.div_start) begin
            dneg_ff <= sum_ff[SumW-1];
            dq_ff   <= sum_ff[SumW-1] ? -sum_ff : sum_ff;
            dr_ff   <= '0;
            dd_ff   <= SumW'(cnt_ff);
            dn_ff   <= 7'(SumW);
         end
         if (cmd.ext_update) begin
            if (cnt_ff == CntW'(1)) begin
               lo_ff <= newest_ff;
               hi_ff <= newest_ff;
            end else begin
               if (newest_ff < lo_ff) lo_ff <= newest_ff;
               if (newest_ff > hi_ff) hi_ff <= newest_ff;
            end
         end
         if (cmd.scan_start) begin
            scan_ff       <= '0;
            scan_rd_ff    <= 1'b0;
            scan_first_ff <= 1'b1;
         end
         if (cmd.scan_step) begin
            // One read issued per cycle; fold the previous read's data
            scan_rd_ff <= (scan_ff < cnt_ff);
            if (scan_ff < cnt_ff) scan_ff <= scan_ff + 1'b1;
            if (scan_rd_ff) begin
               scan_first_ff <= 1'b0;
               if (scan_first_ff || mem_rd < lo_ff) lo_ff <= mem_rd;
               if (scan_first_ff || mem_rd > hi_ff) hi_ff <= mem_rd;
            end
         end
         if (cmd.rsp_load && cmd.accept_flag) begin
            mean_ff <= dneg_ff ? -dq_ff[SampleW-1:0] : dq_ff[SampleW-1:0];
         end
      end
   end

   // Request capture
   always_ff @(posedge clock) begin
      if (cmd.latch) req_ff <= req_data;
   end

   // Result register
   logic signed [SampleW-1:0] mean_out;
   always_comb mean_out = dneg_ff ? -dq_ff[SampleW-1:0] : dq_ff[SampleW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_data.accepted      <= cmd.accept_flag;
         rsp_data.current_value <= cmd.clear ? '0 : newest_ff;
         rsp_data.average_value <= cmd.clear ? '0 :
                                   (cmd.accept_flag ? mean_out : mean_ff);
         rsp_data.minimum_value <= cmd.clear ? '0 : lo_ff;
         rsp_data.maximum_value <= cmd.clear ? '0 : hi_ff;
         rsp_data.sample_count  <= cmd.clear ? '0 : SpanW'(cnt_ff);
      end
   end

endmodule

// ===== sv/sws_ctrl.sv =====
// ---------------------------------------------------------------------------
// sws_ctrl
// Controller: sequences gate check, ring update, rescan and division.
// ---------------------------------------------------------------------------
module sws_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_func,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  sws_pkg::sws_sts_type sts,
   output sws_pkg::sws_cmd_type cmd
);
   import sws_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_INTDIV, S_GATE, S_CHECK, S_READ, S_WRITE, S_EXT,
      S_SCAN, S_DIVSTART, S_DIV, S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      clr_ff, clr_in;

   logic take_req, rsp_free;
   always_comb begin
      rsp_free  = !rsp_valid_ff || !rsp_stall;
      req_stall = (state_ff != S_IDLE);
      take_req  = req_valid && !req_stall;
      rsp_valid = rsp_valid_ff;
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      clr_in       = clr_ff;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (take_req) begin
               cmd.latch = 1'b1;
               clr_in    = (req_func == FUNC_CLEAR);
               state_in  = S_INTDIV;
            end
         end
         S_INTDIV: begin
            if (clr_ff) begin
               state_in = S_DONE;
            end else if (sts.int_done) begin
               state_in = S_GATE;
            end else begin
               cmd.int_step = 1'b1;
            end
         end
         S_GATE: begin
            if (sts.gate_open) begin
               cmd.restart = sts.needs_restart;
               state_in = S_READ;
            end else begin
               state_in = S_DONE;
            end
         end
         S_READ: begin
            cmd.mem_rd_old = 1'b1;
            state_in = S_WRITE;
         end
         S_WRITE: begin
            cmd.record = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (sts.was_full && sts.old_is_ext && !sts.first_sample) begin
               cmd.scan_start = 1'b1;
               state_in = S_SCAN;
            end else begin
               state_in = S_EXT;
            end
         end
         S_EXT: begin
            cmd.ext_update = 1'b1;
            state_in = S_DIVSTART;
         end
         S_SCAN: begin
            if (sts.scan_done) state_in = S_DIVSTART;
            else cmd.scan_step = 1'b1;
         end
         S_DIVSTART: begin
            cmd.div_start = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (sts.div_done) begin
               if (rsp_free) begin
                  cmd.rsp_load    = 1'b1;
                  cmd.accept_flag = 1'b1;
                  rsp_valid_in    = 1'b1;
                  state_in        = S_IDLE;
               end
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               cmd.rsp_load = 1'b1;
               cmd.clear    = clr_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         clr_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         clr_ff       <= clr_in;
      end
   end

endmodule

// ===== sv/sliding_window_stats_unit.sv =====
// Sequence: a clear item skips the interval division and goes to the result; a
// rejected sample ends after the interval division (none with a sampling rate
// of zero) and the gate check; a recorded sample adds the ring update and the average division, and a rescan if needed.
// One item at a time: the input stalls while the serial divider (one bit per
// cycle) and the one-read-per-cycle ring rescan work on the current item.
// Reset: synchronous; configuration registers return to their defaults, statistics zero.
// ---------------------------------------------------------------------------
// sliding_window_stats_unit
// Sliding window min, max and average of gated Q16.16 samples.
// ---------------------------------------------------------------------------
module sliding_window_stats_unit #(
   parameter int MaxSpan = 256
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  sws_pkg::req_type            req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output sws_pkg::rsp_type            rsp_data,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [sws_pkg::CsrIdxW-1:0] csr_index,
   input  logic [31:0]                 csr_wdata
);
   import sws_pkg::*;

   sws_cmd_type cmd;
   sws_sts_type sts;

   // Register writes are always taken; the host must write only between items, the block does not enforce it
   assign csr_ready = 1'b1;

   sws_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_func  (req_data.func),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   sws_datapath #(.MaxSpan(MaxSpan)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== sv/sws_checker.sv =====
// ---------------------------------------------------------------------------
// sws_checker
// Port level checks for the sliding window statistics unit.
// ---------------------------------------------------------------------------
module sws_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input sws_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input sws_pkg::rsp_type rsp_data
);
   import sws_pkg::*;

   // A transfer in is followed by a stalled input
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input not stalled after transfer");

   // A result not accepted with an empty window reports zero extrema
   a_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.accepted && rsp_data.sample_count == '0) |->
      (rsp_data.minimum_value == '0 && rsp_data.maximum_value == '0))
      else $error("empty window with nonzero extrema");

   // Accepted sample leaves at least one in the window
   a_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.accepted) |-> (rsp_data.sample_count != '0))
      else $error("accepted sample with empty window");

   // Stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");

endmodule

bind sliding_window_stats_unit sws_checker u_sws_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
